[hw/rtl/ssi_pkg.sv]
// ----------------------------------------------------------------------------
// Sphere-sphere intersect package
// Shared types and constants for the sphere pair intersection pipeline.
// ----------------------------------------------------------------------------
package ssi_pkg;

    // guard bits added below the unit of the centre distance length
    localparam int GUARD     = 16;
    localparam int TOL_W     = 32;
    localparam logic [TOL_W-1:0] TOL_RESET = 32'd17;

    typedef enum logic [1:0] {
        REL_SEPARATE = 2'd0,
        REL_TOUCHING = 2'd1,
        REL_OVERLAP  = 2'd2
    } relation_t;

endpackage

[hw/rtl/ssi_sqrt.sv]
// ----------------------------------------------------------------------------
// Pipelined integer square root
// One result bit per stage, digit by digit, with a sideband carried along.
// ----------------------------------------------------------------------------
module ssi_sqrt #(
    parameter int RB = 42,
    parameter int SW = 8
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  logic [2*RB-1:0] in_x,
    input  logic [SW-1:0]   in_side,
    output logic            out_valid,
    output logic [RB-1:0]   out_root,
    output logic [SW-1:0]   out_side
);

    localparam int XW = 2 * RB;
    localparam int MW = RB + 2;

    logic          valid_reg [RB];
    logic [MW-1:0] rem_reg   [RB];
    logic [RB-1:0] root_reg  [RB];
    logic [XW-1:0] x_reg     [RB];
    logic [SW-1:0] side_reg  [RB];

    logic          valid_next [RB];
    logic [MW-1:0] rem_next   [RB];
    logic [RB-1:0] root_next  [RB];
    logic [XW-1:0] x_next     [RB];
    logic [SW-1:0] side_next  [RB];

    for (genvar k = 0; k < RB; k++) begin : g_stage
        logic          pv;
        logic [MW-1:0] prem;
        logic [RB-1:0] proot;
        logic [XW-1:0] px;
        logic [SW-1:0] pside;
        logic [MW-1:0] rem_sh;
        logic [MW-1:0] trial;

        if (k == 0) begin : g_first
            assign pv    = in_valid;
            assign prem  = '0;
            assign proot = '0;
            assign px    = in_x;
            assign pside = in_side;
        end else begin : g_rest
            assign pv    = valid_reg[k-1];
            assign prem  = rem_reg[k-1];
            assign proot = root_reg[k-1];
            assign px    = x_reg[k-1];
            assign pside = side_reg[k-1];
        end

        always_comb
        begin
            rem_sh        = {prem[MW-3:0], px[XW-1:XW-2]};
            trial         = {proot, 2'b01};
            valid_next[k] = pv;
            x_next[k]     = {px[XW-3:0], 2'b00};
            side_next[k]  = pside;
            if (rem_sh >= trial)
            begin
                rem_next[k]  = rem_sh - trial;
                root_next[k] = {proot[RB-2:0], 1'b1};
            end
            else
            begin
                rem_next[k]  = rem_sh;
                root_next[k] = {proot[RB-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < RB; i++)
                valid_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            for (int i = 0; i < RB; i++)
                valid_reg[i] <= valid_next[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < RB; i++)
            begin
                rem_reg[i]  <= rem_next[i];
                root_reg[i] <= root_next[i];
                x_reg[i]    <= x_next[i];
                side_reg[i] <= side_next[i];
            end
        end
    end

    assign out_valid = valid_reg[RB-1];
    assign out_root  = root_reg[RB-1];
    assign out_side  = side_reg[RB-1];

endmodule

[hw/rtl/ssi_div.sv]
// ----------------------------------------------------------------------------
// Pipelined three-lane divider
// Restoring division, one quotient bit per stage, shared divisor per item.
// ----------------------------------------------------------------------------
module ssi_div #(
    parameter int QW = 24,
    parameter int DW = 42,
    parameter int NW = 65,
    parameter int SW = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [NW-1:0] in_num [3],
    input  logic [DW-1:0] in_den,
    input  logic [SW-1:0] in_side,
    output logic          out_valid,
    output logic [QW-1:0] out_quo [3],
    output logic [SW-1:0] out_side
);

    logic          valid_reg [QW];
    logic [DW-1:0] den_reg   [QW];
    logic [SW-1:0] side_reg  [QW];
    logic [DW-1:0] rem_reg   [QW][3];
    logic [QW-1:0] lo_reg    [QW][3];
    logic [QW-1:0] q_reg     [QW][3];

    logic [DW-1:0] rem_next  [QW][3];
    logic [QW-1:0] lo_next   [QW][3];
    logic [QW-1:0] q_next    [QW][3];
    logic          valid_next[QW];
    logic [DW-1:0] den_next  [QW];
    logic [SW-1:0] side_next [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        for (genvar l = 0; l < 3; l++) begin : g_lane
            logic [DW-1:0] prem;
            logic [QW-1:0] plo;
            logic [QW-1:0] pq;
            logic [DW:0]   rem_sh;
            logic [DW:0]   diff;

            if (k == 0) begin : g_first
                assign prem = DW'(in_num[l][NW-1:QW]);
                assign plo  = in_num[l][QW-1:0];
                assign pq   = '0;
            end else begin : g_rest
                assign prem = rem_reg[k-1][l];
                assign plo  = lo_reg[k-1][l];
                assign pq   = q_reg[k-1][l];
            end

            always_comb
            begin
                rem_sh          = {prem, plo[QW-1]};
                diff            = rem_sh - {1'b0, den_next[k]};
                lo_next[k][l]   = plo << 1;
                if (rem_sh >= {1'b0, den_next[k]})
                begin
                    rem_next[k][l] = diff[DW-1:0];
                    q_next[k][l]   = {pq[QW-2:0], 1'b1};
                end
                else
                begin
                    rem_next[k][l] = rem_sh[DW-1:0];
                    q_next[k][l]   = {pq[QW-2:0], 1'b0};
                end
            end
        end

        if (k == 0) begin : g_ctl_first
            assign valid_next[k] = in_valid;
            assign den_next[k]   = in_den;
            assign side_next[k]  = in_side;
        end else begin : g_ctl_rest
            assign valid_next[k] = valid_reg[k-1];
            assign den_next[k]   = den_reg[k-1];
            assign side_next[k]  = side_reg[k-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < QW; i++)
                valid_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            for (int i = 0; i < QW; i++)
                valid_reg[i] <= valid_next[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < QW; i++)
            begin
                den_reg[i]  <= den_next[i];
                side_reg[i] <= side_next[i];
                for (int j = 0; j < 3; j++)
                begin
                    rem_reg[i][j] <= rem_next[i][j];
                    lo_reg[i][j]  <= lo_next[i][j];
                    q_reg[i][j]   <= q_next[i][j];
                end
            end
        end
    end

    assign out_valid = valid_reg[QW-1];
    assign out_side  = side_reg[QW-1];
    assign out_quo   = q_reg[QW-1];

endmodule

[hw/rtl/sphere_sphere_intersect.sv]
// ----------------------------------------------------------------------------
// Sphere-sphere intersection test
// Classifies a sphere pair as separate, touching or overlapping and gives
// the contact point of touching spheres.
// ----------------------------------------------------------------------------
// The block takes one sphere pair per clock while the output is not stalled
// and returns one result per pair, in order. A pair passes through the front
// stages that unpack, square, sum and classify, the bit-per-stage square root
// of the squared centre distance, the numerator stage, the bit-per-stage
// divider that scales the unit direction and the output stage; root and
// divider are both fully pipelined. A stall on the output side holds every
// stage in place, empty ones included, so the input also waits while the
// output holds an untaken result; empty stages are not squeezed out.
module sphere_sphere_intersect import ssi_pkg::*; #(
    parameter int COORD_BITS = 24
) (
    input  logic clk,
    input  logic rst_n,

    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [TOL_W-1:0]    cfg_data,     // tolerance

    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // centre_a_x, centre_a_y, centre_a_z, radius_a,
    // centre_b_x, centre_b_y, centre_b_z, radius_b, zero fill
    input  logic [((8*COORD_BITS-2+7)/8)*8-1:0]    s_axis_tdata,

    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // relation, contact_x, contact_y, contact_z, point_saturated, zero fill
    output logic [((3*COORD_BITS+3+7)/8)*8-1:0]    m_axis_tdata
);

    localparam int C     = COORD_BITS;
    localparam int RW    = C - 1;             // radius width
    localparam int MW    = C + 1;             // axis delta magnitude
    localparam int SQW   = 2 * MW;
    localparam int DISTW = SQW + 2;
    localparam int SUMW  = C;
    localparam int RSQW  = 2 * C;
    localparam int PW    = MW + RW;           // |d| * radius_a
    localparam int CW    = ((DISTW > TOL_W) ? DISTW : TOL_W) + 1;
    localparam int RB    = C + 2 + GUARD;     // root bits
    localparam int NW    = PW + GUARD + 1;    // rounded numerator
    localparam int OUT_TW = ((3*C+3+7)/8)*8;
    localparam int SW1   = 3*C + 3*PW + 3 + 2;
    localparam int SW2   = 3*C + 3 + 2 + 1;

    logic [TOL_W-1:0] tol_reg;

    // config write: always ready; it must be written only while idle, which the block itself does not enforce
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tol_reg <= TOL_RESET;
        else if (cfg_valid)
            tol_reg <= cfg_data;
    end

    // pipeline advance: everything moves unless the output holds an
    // untaken result
    logic out_valid_reg;
    logic en;

    assign en            = m_axis_tready || !out_valid_reg;
    assign s_axis_tready = en;

    // ---------------- stage 1: unpack, axis deltas, radius sum
    logic                v1_reg;
    logic signed [C-1:0] a1_reg [3];
    logic signed [C:0]   d1_reg [3];
    logic [RW-1:0]       ra1_reg;
    logic [SUMW-1:0]     rs1_reg;

    logic signed [C-1:0] in_a [3];
    logic signed [C-1:0] in_b [3];
    logic [RW-1:0]       in_ra;
    logic [RW-1:0]       in_rb;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            in_a[i] = s_axis_tdata[i*C +: C];
            in_b[i] = s_axis_tdata[3*C+RW+i*C +: C];
        end
        in_ra = s_axis_tdata[3*C +: RW];
        in_rb = s_axis_tdata[6*C+RW +: RW];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                a1_reg[i] <= in_a[i];
                d1_reg[i] <= {in_b[i][C-1], in_b[i]} - {in_a[i][C-1], in_a[i]};
            end
            ra1_reg <= in_ra;
            rs1_reg <= SUMW'(in_ra) + SUMW'(in_rb);
        end
    end

    // ---------------- stage 2: squares and radius products
    logic                v2_reg;
    logic signed [C-1:0] a2_reg   [3];
    logic [2:0]          sign2_reg;
    logic [SQW-1:0]      dsq2_reg [3];
    logic [PW-1:0]       p2_reg   [3];
    logic [RSQW-1:0]     rsq2_reg;

    logic [MW-1:0] mag1 [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            mag1[i] = d1_reg[i][C] ? MW'(-d1_reg[i]) : MW'(d1_reg[i]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                a2_reg[i]    <= a1_reg[i];
                sign2_reg[i] <= d1_reg[i][C];
                dsq2_reg[i]  <= SQW'(mag1[i]) * SQW'(mag1[i]);
                p2_reg[i]    <= PW'(mag1[i]) * PW'(ra1_reg);
            end
            rsq2_reg <= RSQW'(rs1_reg) * RSQW'(rs1_reg);
        end
    end

    // ---------------- stage 3: squared centre distance
    logic                v3_reg;
    logic signed [C-1:0] a3_reg [3];
    logic [2:0]          sign3_reg;
    logic [PW-1:0]       p3_reg [3];
    logic [RSQW-1:0]     rsq3_reg;
    logic [DISTW-1:0]    dist3_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a3_reg    <= a2_reg;
            sign3_reg <= sign2_reg;
            p3_reg    <= p2_reg;
            rsq3_reg  <= rsq2_reg;
            dist3_reg <= DISTW'(dsq2_reg[0]) + DISTW'(dsq2_reg[1]) + DISTW'(dsq2_reg[2]);
        end
    end

    // ---------------- stage 4: classify against the tolerance band
    logic                v4_reg;
    logic signed [C-1:0] a4_reg [3];
    logic [2:0]          sign4_reg;
    logic [PW-1:0]       p4_reg [3];
    logic [DISTW-1:0]    dist4_reg;
    relation_t           rel4_reg;
    relation_t           rel3;

    always_comb
    begin
        if (CW'(dist3_reg) > CW'(rsq3_reg) + CW'(tol_reg))
            rel3 = REL_SEPARATE;
        else if (CW'(dist3_reg) + CW'(tol_reg) < CW'(rsq3_reg))
            rel3 = REL_OVERLAP;
        else
            rel3 = REL_TOUCHING;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a4_reg    <= a3_reg;
            sign4_reg <= sign3_reg;
            p4_reg    <= p3_reg;
            dist4_reg <= dist3_reg;
            rel4_reg  <= rel3;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= s_axis_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // ---------------- length of B - A, in units 2^-GUARD of a coordinate
    logic [SW1-1:0] side1_in;
    logic [SW1-1:0] side1_out;
    logic           sq_valid;
    logic [RB-1:0]  sq_root;

    assign side1_in = {rel4_reg, sign4_reg, p4_reg[2], p4_reg[1], p4_reg[0],
                       a4_reg[2], a4_reg[1], a4_reg[0]};

    ssi_sqrt #(
        .RB (RB),
        .SW (SW1)
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v4_reg),
        .in_x      ({dist4_reg, {(2*GUARD){1'b0}}}),
        .in_side   (side1_in),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_side  (side1_out)
    );

    // ---------------- stage 5: rounded numerators
    logic                v5_reg;
    logic [NW-1:0]       num5_reg [3];
    logic [RB-1:0]       len5_reg;
    logic [SW2-1:0]      side5_reg;
    logic [PW-1:0]       p_sq [3];
    logic                len_zero;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            p_sq[i] = side1_out[3*C+i*PW +: PW];
        len_zero = (sq_root == '0);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
                num5_reg[i] <= NW'({p_sq[i], {GUARD{1'b0}}}) + NW'(sq_root >> 1);
            len5_reg  <= sq_root;
            side5_reg <= {len_zero, side1_out[SW1-1 -: 5], side1_out[3*C-1:0]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v5_reg <= 1'b0;
        else if (en)
            v5_reg <= sq_valid;
    end

    // ---------------- offsets along each axis
    logic           dv_valid;
    logic [C-1:0]   dv_quo [3];
    logic [SW2-1:0] side2_out;

    ssi_div #(
        .QW (C),
        .DW (RB),
        .NW (NW),
        .SW (SW2)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v5_reg),
        .in_num    (num5_reg),
        .in_den    (len5_reg),
        .in_side   (side5_reg),
        .out_valid (dv_valid),
        .out_quo   (dv_quo),
        .out_side  (side2_out)
    );

    // ---------------- output stage: apply offset, saturate, mask
    relation_t           rel_reg;
    logic signed [C-1:0] pt_reg [3];
    logic                sat_reg;

    relation_t           rel_d;
    logic [2:0]          sign_d;
    logic                zero_d;
    logic signed [C-1:0] a_d   [3];
    logic signed [C+1:0] v_d   [3];
    logic signed [C-1:0] pt_d  [3];
    logic [2:0]          sat_d;

    always_comb
    begin
        rel_d  = relation_t'(side2_out[3*C+3 +: 2]);
        sign_d = side2_out[3*C +: 3];
        zero_d = side2_out[SW2-1];
        for (int i = 0; i < 3; i++)
        begin
            a_d[i] = side2_out[i*C +: C];
            if (zero_d)
                v_d[i] = (C+2)'(a_d[i]);
            else if (sign_d[i])
                v_d[i] = (C+2)'(a_d[i]) - $signed({2'b00, dv_quo[i]});
            else
                v_d[i] = (C+2)'(a_d[i]) + $signed({2'b00, dv_quo[i]});
            // in range when the top three bits agree
            sat_d[i] = !(v_d[i][C+1:C-1] == 3'b000 || v_d[i][C+1:C-1] == 3'b111);
            if (!sat_d[i])
                pt_d[i] = v_d[i][C-1:0];
            else if (v_d[i][C+1])
                pt_d[i] = {1'b1, {(C-1){1'b0}}};
            else
                pt_d[i] = {1'b0, {(C-1){1'b1}}};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rel_reg <= rel_d;
            if (rel_d == REL_TOUCHING)
            begin
                pt_reg  <= pt_d;
                sat_reg <= |sat_d;
            end
            else
            begin
                for (int i = 0; i < 3; i++)
                    pt_reg[i] <= '0;
                sat_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= dv_valid;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_TW'({sat_reg, pt_reg[2], pt_reg[1], pt_reg[0], rel_reg});

    // ---------------- checks
    a_rel_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (rel_reg == REL_SEPARATE || rel_reg == REL_TOUCHING ||
                           rel_reg == REL_OVERLAP))
        else $error("relation code out of range");

    a_point_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && rel_reg != REL_TOUCHING) |->
            (pt_reg[0] == '0 && pt_reg[1] == '0 && pt_reg[2] == '0 && !sat_reg))
        else $error("contact point set for non-touching pair");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_axis_tready) |=> (out_valid_reg && $stable(rel_reg)))
        else $error("result changed under stall");

    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (v4_reg && !en) |=> (v4_reg && $stable(dist4_reg)))
        else $error("pipeline stage moved under stall");

endmodule

[dv/tb_top.sv]
// ----------------------------------------------------------------------------
// Sphere-sphere intersect testbench
// Drives sphere pairs into the stream slave port with random gaps, checks
// every result transfer against an in-bench prediction of the relation and
// contact point, and walks the tolerance register through several values.
// ----------------------------------------------------------------------------
module tb_top;
    import ssi_pkg::*;

    localparam int CB       = 24;
    localparam int PAIR_W   = 8*CB-2;
    localparam int IN_W     = ((8*CB-2+7)/8)*8;
    localparam int OUT_W    = ((3*CB+3+7)/8)*8;
    localparam int LATENCY  = 72;
    localparam int LIMIT    = 400000;
    localparam longint CMAX = 8388607;
    localparam longint CMIN = -8388608;

    typedef struct packed {
        logic signed [CB-1:0] ax, ay, az;
        logic [CB-2:0]        ra;
        logic signed [CB-1:0] bx, by, bz;
        logic [CB-2:0]        rb;
    } sphere_pair_t;

    typedef struct packed {
        relation_t     rel;
        logic [CB-1:0] cx, cy, cz;
        logic          sat;
    } contact_t;

    logic clk;
    logic rst_n;
    logic cfg_valid;
    logic cfg_ready;
    logic [TOL_W-1:0] cfg_data;
    logic s_axis_tvalid;
    logic s_axis_tready;
    // centre_a_x, centre_a_y, centre_a_z, radius_a,
    // centre_b_x, centre_b_y, centre_b_z, radius_b, zero fill
    logic [IN_W-1:0] s_axis_tdata;
    logic m_axis_tvalid;
    logic m_axis_tready;
    // relation, contact_x, contact_y, contact_z, point_saturated, zero fill
    logic [OUT_W-1:0] m_axis_tdata;

    logic [TOL_W-1:0] tol_shadow;
    contact_t expected_contacts[$];
    int  mismatches;
    int  cycles;
    int  rx_hold;
    bit  idle_on;

    sphere_sphere_intersect #(.COORD_BITS(CB)) DUT (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Watchdog: end the run if the pipeline hangs.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Predict the relation and contact point of one pair with exact integer math.
    function automatic contact_t predict_contact(sphere_pair_t p, logic [TOL_W-1:0] tol);
        contact_t     r;
        longint       a[3];
        longint       d[3];
        longint       v;
        logic [63:0]  m[3];
        logic [127:0] dist_sq;
        logic [127:0] rsum;
        logic [127:0] x;
        logic [63:0]  len;
        logic [63:0]  cand;
        logic [63:0]  num;
        logic [63:0]  q;
        r = '0;
        a[0] = p.ax; a[1] = p.ay; a[2] = p.az;
        d[0] = longint'(p.bx) - a[0];
        d[1] = longint'(p.by) - a[1];
        d[2] = longint'(p.bz) - a[2];
        dist_sq = '0;
        for (int i = 0; i < 3; i++)
        begin
            m[i] = d[i] < 0 ? 64'(-d[i]) : 64'(d[i]);
            dist_sq = dist_sq + 128'(m[i]) * 128'(m[i]);
        end
        rsum = (128'(p.ra) + 128'(p.rb)) * (128'(p.ra) + 128'(p.rb));
        if (dist_sq > rsum + 128'(tol))
            r.rel = REL_SEPARATE;
        else if (dist_sq + 128'(tol) < rsum)
            r.rel = REL_OVERLAP;
        else
            r.rel = REL_TOUCHING;
        if (r.rel == REL_TOUCHING)
        begin
            // length of B - A with GUARD extra fraction bits
            x = dist_sq << (2*GUARD);
            len = '0;
            for (int b = 45; b >= 0; b--)
            begin
                cand = len | (64'd1 << b);
                if (128'(cand) * 128'(cand) <= x)
                    len = cand;
            end
            for (int i = 0; i < 3; i++)
            begin
                v = a[i];
                if (len != 0)
                begin
                    num = ((m[i] * 64'(p.ra)) << GUARD) + (len >> 1);
                    q = num / len;
                    if (q > (64'd1 << 40))
                        q = 64'd1 << 40;
                    v = d[i] < 0 ? v - longint'(q) : v + longint'(q);
                end
                if (v > CMAX) begin v = CMAX; r.sat = 1'b1; end
                if (v < CMIN) begin v = CMIN; r.sat = 1'b1; end
                if (i == 0) r.cx = v[CB-1:0];
                if (i == 1) r.cy = v[CB-1:0];
                if (i == 2) r.cz = v[CB-1:0];
            end
        end
        return r;
    endfunction

    // Result checker: compare each output transfer with the oldest prediction.
    always @(posedge clk)
    begin
        contact_t got;
        contact_t exp_c;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.rel = relation_t'(m_axis_tdata[1:0]);
            got.cx  = m_axis_tdata[25:2];
            got.cy  = m_axis_tdata[49:26];
            got.cz  = m_axis_tdata[73:50];
            got.sat = m_axis_tdata[74];
            if (expected_contacts.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transfer %h", m_axis_tdata);
            end
            else
            begin
                exp_c = expected_contacts.pop_front();
                if (got.rel !== exp_c.rel || got.cx !== exp_c.cx || got.cy !== exp_c.cy
                    || got.cz !== exp_c.cz || got.sat !== exp_c.sat)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp rel=%0d pt=(%h,%h,%h) sat=%b got rel=%0d pt=(%h,%h,%h) sat=%b",
                                 exp_c.rel, exp_c.cx, exp_c.cy, exp_c.cz, exp_c.sat,
                                 got.rel, got.cx, got.cy, got.cz, got.sat);
                end
            end
            rx_hold = idle_on ? $urandom_range(0, 18) : 0;
        end
    end

    // Output back-pressure: hold tready low for the drawn stall, then raise it.
    always @(negedge clk)
    begin
        if (rx_hold > 0)
        begin
            m_axis_tready <= 1'b0;
            rx_hold--;
        end
        else
            m_axis_tready <= 1'b1;
    end

    // Send one pair; the prediction is queued at the accepting edge.
    task automatic send_pair(sphere_pair_t p);
        int gap;
        gap = idle_on ? $urandom_range(0, 18) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, p.rb, p.bz, p.by, p.bx, p.ra, p.az, p.ay, p.ax};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        expected_contacts.push_back(predict_contact(p, tol_shadow));
    endtask

    task automatic drain_results();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (expected_contacts.size() != 0) @(posedge clk);
    endtask

    // Write the tolerance register once the pipeline is empty.
    task automatic write_tolerance(logic [TOL_W-1:0] value);
        drain_results();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        tol_shadow = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic sphere_pair_t make_pair(longint ax, longint ay, longint az, longint ra,
                                               longint bx, longint by, longint bz, longint rb);
        sphere_pair_t p;
        p.ax = ax[CB-1:0]; p.ay = ay[CB-1:0]; p.az = az[CB-1:0]; p.ra = ra[CB-2:0];
        p.bx = bx[CB-1:0]; p.by = by[CB-1:0]; p.bz = bz[CB-1:0]; p.rb = rb[CB-2:0];
        return p;
    endfunction

    // Build a pair whose radius sum lands close to the centre distance.
    function automatic sphere_pair_t near_touch_pair(int span);
        sphere_pair_t p;
        longint a[3];
        longint d[3];
        real    len;
        longint target;
        longint ra;
        for (int i = 0; i < 3; i++)
        begin
            a[i] = $signed($urandom_range(0, 2*(1 << 21))) - (1 << 21);
            d[i] = $signed($urandom_range(0, 2*span)) - span;
        end
        len = $sqrt(real'(d[0]*d[0] + d[1]*d[1] + d[2]*d[2]));
        target = longint'(len) + $signed($urandom_range(0, 4)) - 2;
        if (target < 0) target = 0;
        ra = $urandom_range(0, int'(target));
        p = make_pair(a[0], a[1], a[2], ra, a[0]+d[0], a[1]+d[1], a[2]+d[2], target - ra);
        return p;
    endfunction

    function automatic sphere_pair_t noise_pair();
        sphere_pair_t p;
        p = PAIR_W'({$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom()});
        return p;
    endfunction

    task automatic test_directed();
        idle_on = 1'b0;
        // coincident centres with small radii: touching, point is centre A
        send_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0));
        send_pair(make_pair(1234, -77, 5, 0, 1234, -77, 5, 3));
        // extreme corners, far apart
        send_pair(make_pair(CMIN, CMIN, CMIN, 0, CMAX, CMAX, CMAX, 0));
        send_pair(make_pair(CMAX, CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, CMAX));
        // exact touch along each axis and on a 3-4-5 diagonal
        send_pair(make_pair(0, 0, 0, 4096, 8192, 0, 0, 4096));
        send_pair(make_pair(0, 0, 0, 100, 0, -300, 0, 200));
        send_pair(make_pair(0, 0, 0, 1, 0, 0, 5, 4));
        send_pair(make_pair(-10, 20, 0, 2, -10+3, 20+4, 0, 3));
        // overlap and separation well outside the band
        send_pair(make_pair(0, 0, 0, 5000, 100, 0, 0, 5000));
        send_pair(make_pair(0, 0, 0, 10, 1000, 0, 0, 10));
        send_pair(make_pair(CMIN, 0, CMAX, CMAX, CMIN, 0, CMAX, CMAX));
        drain_results();
        // huge tolerance: every pair here touches, contact point saturates near the edge
        write_tolerance(32'hFFFF_FFFF);
        send_pair(make_pair(CMAX-7, CMIN+7, 0, 65000, CMAX, CMIN, 0, 0));
        send_pair(make_pair(0, 0, 0, 10, 1, 0, 0, 10));
        send_pair(make_pair(CMIN+3, 0, 0, 60000, CMIN, 0, 0, 0));
        send_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0));
        write_tolerance(32'd0);
        send_pair(make_pair(0, 0, 0, 3, 0, 0, 5, 2));
        send_pair(make_pair(0, 0, 0, 3, 0, 0, 5, 1));
        send_pair(make_pair(0, 0, 0, 3, 0, 0, 5, 3));
        write_tolerance(TOL_RESET);
    endtask

    task automatic test_random_mix(int count, bit idle);
        int kind;
        idle_on = idle;
        for (int i = 0; i < count; i++)
        begin
            kind = $urandom_range(0, 7);
            if (kind < 5)
                send_pair(near_touch_pair(kind < 2 ? 300 : (1 << 20)));
            else
                send_pair(noise_pair());
        end
    endtask

    task automatic test_drain_pause();
        // hold the sender off until every result is back, then resume
        test_random_mix(20, 1'b1);
        drain_results();
        test_random_mix(20, 1'b1);
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        rx_hold = 0;
        idle_on = 1'b0;
        mismatches = 0;
        cycles = 0;
        tol_shadow = TOL_RESET;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_random_mix(150, 1'b1);
        test_drain_pause();
        test_random_mix(60, 1'b0);
        write_tolerance(32'd0);
        test_random_mix(120, 1'b1);
        write_tolerance($urandom());
        test_random_mix(120, 1'b1);
        write_tolerance(32'hFFFF_FFFF);
        test_random_mix(120, 1'b1);

        drain_results();
        repeat (LATENCY + 8) @(posedge clk);
        if (mismatches == 0 && expected_contacts.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

[filelist.f]
hw/rtl/ssi_pkg.sv
hw/rtl/ssi_sqrt.sv
hw/rtl/ssi_div.sv
hw/rtl/sphere_sphere_intersect.sv
dv/tb_top.sv
